// ===== hw/rtl/fvn_pkg.sv =====
// shared constants, types and helper functions for the fractal value noise block
`default_nettype none

package fvn_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int SPAN_BITS          = 12;
  localparam int SEED_BITS          = 64;
  localparam int SP_BITS            = 10;
  localparam int HEIGHT_BITS        = 8;
  localparam int CFG_INDEX_BITS     = 1;
  localparam int CFG_DATA_BITS      = 64;
  localparam int QUEUE_DEPTH        = 4;
  localparam int INTERP_BITS        = 18;
  localparam int BYTE_BITS          = 8;
  localparam int BLEND_BITS         = 12;

  localparam logic [SEED_BITS-1:0] SEED_RESET = 64'h0;
  localparam logic [SPAN_BITS-1:0] SPAN_RESET = 12'd512;

  localparam logic [63:0] HASH_BASIS    = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] HASH_MUL1     = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] HASH_MUL2     = 64'hc2b2_ae3d_27d4_eb4f;
  localparam logic [63:0] HASH_MUL3     = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] FINE_SEED_XOR = 64'h0000_0000_00ab_cdef;

  localparam logic [SP_BITS-1:0] SP_COARSE_MIN = 10'd8;
  localparam logic [SP_BITS-1:0] SP_FINE_MIN   = 10'd4;

  // floor(v * R / 2^16) equals floor(v / d) over the value ranges used here
  localparam logic [15:0] DIV5_RECIP  = 16'd13108;
  localparam logic [15:0] DIV11_RECIP = 16'd5958;
  localparam logic [12:0] DIV10_RECIP = 13'd6554;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SEED,
    CFG_SPAN
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] m1;
    logic [31:0] m2;
  } mul_parts_t;

  function automatic logic [SP_BITS-1:0] spacing_coarse(input logic [SPAN_BITS-1:0] span);
    logic [SPAN_BITS+15:0] prod;
    logic [SPAN_BITS-1:0]  q;
    prod = (SPAN_BITS+16)'(span) * (SPAN_BITS+16)'(DIV5_RECIP);
    q    = prod[SPAN_BITS+15:16];
    return (q < SPAN_BITS'(SP_COARSE_MIN)) ? SP_COARSE_MIN : q[SP_BITS-1:0];
  endfunction

  function automatic logic [SP_BITS-1:0] spacing_fine(input logic [SPAN_BITS-1:0] span);
    logic [SPAN_BITS+15:0] prod;
    logic [SPAN_BITS-1:0]  q;
    prod = (SPAN_BITS+16)'(span) * (SPAN_BITS+16)'(DIV11_RECIP);
    q    = prod[SPAN_BITS+15:16];
    return (q < SPAN_BITS'(SP_FINE_MIN)) ? SP_FINE_MIN : q[SP_BITS-1:0];
  endfunction

  // low 64 bits of a 64x64 product as three 32x32 partial products
  function automatic mul_parts_t mul_parts(input logic [63:0] a, input logic [63:0] c);
    mul_parts_t p;
    p.lo = 64'(a[31:0]) * 64'(c[31:0]);
    p.m1 = a[63:32] * c[31:0];
    p.m2 = a[31:0] * c[63:32];
    return p;
  endfunction

  function automatic logic [63:0] mul_sum(input mul_parts_t p);
    logic [31:0] mid;
    mid = p.m1 + p.m2;
    return p.lo + {mid, 32'h0};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fvn_if.sv =====
// coordinate and height channel interfaces
`default_nettype none

interface fvn_coord_if #(
  parameter int COORD_BITS = fvn_pkg::COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] z_coord;

  modport source (output valid, x_coord, z_coord, input ready);
  modport sink   (input valid, x_coord, z_coord, output ready);
endinterface

interface fvn_height_if;
  logic                           valid;
  logic                           ready;
  logic [fvn_pkg::HEIGHT_BITS-1:0] height;

  modport source (output valid, height, input ready);
  modport sink   (input valid, height, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fvn_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, several lanes
`default_nettype none

module fvn_divider #(
  parameter int LANES = 1,
  parameter int NB    = 8,
  parameter int DB    = 10,
  parameter int SB    = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [LANES-1:0][NB-1:0]     num_in,
  input  logic [LANES-1:0][DB-1:0]     rem_in,
  input  logic [LANES-1:0][DB-1:0]     divisor,
  input  logic [SB-1:0]                side_in,
  output logic [LANES-1:0][NB-1:0]     quo,
  output logic [LANES-1:0][DB-1:0]     rem,
  output logic [SB-1:0]                side_out
);

  logic [LANES-1:0][NB-1:0] num_st [NB+1];
  logic [LANES-1:0][DB-1:0] rem_st [NB+1];
  logic [SB-1:0]            side_st [NB+1];
  logic [LANES-1:0][NB-1:0] num_next [NB];
  logic [LANES-1:0][DB-1:0] rem_next [NB];

  // dividend bits leave at the top while quotient bits enter at the bottom
  always_comb begin
    logic [DB:0] t;
    for (int k = 0; k < NB; k++) begin
      for (int l = 0; l < LANES; l++) begin
        t = {rem_st[k][l], num_st[k][l][NB-1]};
        if (t >= {1'b0, divisor[l]}) begin
          rem_next[k][l] = DB'(t - {1'b0, divisor[l]});
          num_next[k][l] = {num_st[k][l][NB-2:0], 1'b1};
        end else begin
          rem_next[k][l] = t[DB-1:0];
          num_next[k][l] = {num_st[k][l][NB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NB; k++) begin
        side_st[k] <= '0;
      end
    end else if (en) begin
      num_st[0]  <= num_in;
      rem_st[0]  <= rem_in;
      side_st[0] <= side_in;
      for (int k = 0; k < NB; k++) begin
        num_st[k+1]  <= num_next[k];
        rem_st[k+1]  <= rem_next[k];
        side_st[k+1] <= side_st[k];
      end
    end
  end

  assign quo      = num_st[NB];
  assign rem      = rem_st[NB];
  assign side_out = side_st[NB];

endmodule

`default_nettype wire

// ===== hw/rtl/fvn_queue.sv =====
// small register queue between the front and back pipelines
`default_nettype none

module fvn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = fvn_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       push_data,
  input  logic                   pop,
  output logic [WIDTH-1:0]       pop_data,
  output fvn_pkg::queue_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign pop_data     = mem[rd_ptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/fvn_front.sv =====
// front pipeline: accepts coordinates and splits them into lattice index and offset
`default_nettype none

module fvn_front #(
  parameter int COORD_BITS = fvn_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst,
  fvn_coord_if.sink                                     coord,
  input  logic [fvn_pkg::SP_BITS-1:0]                   sp_coarse,
  input  logic [fvn_pkg::SP_BITS-1:0]                   sp_fine,
  input  logic                                          full,
  output logic                                          push,
  output logic [4*(COORD_BITS+fvn_pkg::SP_BITS)-1:0]    push_data
);

  localparam int UB = COORD_BITS - 1;
  localparam int LW = COORD_BITS + fvn_pkg::SP_BITS;

  logic                                en;
  logic                                negx;
  logic                                negz;
  logic [UB-1:0]                       ux;
  logic [UB-1:0]                       uz;
  logic [3:0][UB-1:0]                  quo;
  logic [3:0][fvn_pkg::SP_BITS-1:0]    rem;
  logic [3:0][fvn_pkg::SP_BITS-1:0]    dv;
  logic [2:0]                          side_out;

  // floor division of a negative value v goes through ~v = -v-1
  assign negx = coord.x_coord[COORD_BITS-1];
  assign negz = coord.z_coord[COORD_BITS-1];
  assign ux   = negx ? ~coord.x_coord[UB-1:0] : coord.x_coord[UB-1:0];
  assign uz   = negz ? ~coord.z_coord[UB-1:0] : coord.z_coord[UB-1:0];
  assign dv   = {sp_fine, sp_fine, sp_coarse, sp_coarse};

  assign en          = !full || !side_out[0];
  assign coord.ready = en;
  assign push        = side_out[0] && !full;

  fvn_divider #(
    .LANES(4),
    .NB   (UB),
    .DB   (fvn_pkg::SP_BITS),
    .SB   (3)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .num_in  ({uz, ux, uz, ux}),
    .rem_in  ('0),
    .divisor (dv),
    .side_in ({negz, negx, coord.valid}),
    .quo     (quo),
    .rem     (rem),
    .side_out(side_out)
  );

  always_comb begin
    logic                        neg;
    logic [COORD_BITS-1:0]       g;
    logic [fvn_pkg::SP_BITS-1:0] f;
    for (int l = 0; l < 4; l++) begin
      neg = ((l & 1) != 0) ? side_out[2] : side_out[1];
      g   = neg ? ~{1'b0, quo[l]} : {1'b0, quo[l]};
      f   = neg ? dv[l] - fvn_pkg::SP_BITS'(1) - rem[l] : rem[l];
      push_data[l*LW +: LW] = {g, f};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fvn_back.sv =====
// back pipeline: lattice hashing, bilinear blend of both octaves, final mix
`default_nettype none

module fvn_back #(
  parameter int COORD_BITS = fvn_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        empty,
  input  logic [4*(COORD_BITS+fvn_pkg::SP_BITS)-1:0]  entry,
  output logic                                        pop,
  input  logic [fvn_pkg::SEED_BITS-1:0]               seed,
  input  logic [fvn_pkg::SP_BITS-1:0]                 sp_coarse,
  input  logic [fvn_pkg::SP_BITS-1:0]                 sp_fine,
  fvn_height_if.source                                result
);

  localparam int LW  = COORD_BITS + fvn_pkg::SP_BITS;
  localparam int SPB = fvn_pkg::SP_BITS;
  localparam int IB  = fvn_pkg::INTERP_BITS;
  localparam int BB  = fvn_pkg::BYTE_BITS;
  localparam int XB  = fvn_pkg::BLEND_BITS;

  logic                          en;
  logic signed [COORD_BITS-1:0]  g [4];
  logic [3:0][SPB-1:0]           f_in;
  logic [SPB-1:0]                sp_oct [2];
  logic [63:0]                   seed_oct [2];

  fvn_pkg::mul_parts_t           p1_next [8];
  logic [31:0]                   zi_next [8];

  logic [6:1]                    hv;
  logic [3:0][SPB-1:0]           fr [1:6];
  fvn_pkg::mul_parts_t           p1 [8];
  logic [31:0]                   zi1 [8];
  logic [63:0]                   x2 [8];
  fvn_pkg::mul_parts_t           p3 [8];
  logic [63:0]                   x4 [8];
  fvn_pkg::mul_parts_t           p5 [8];
  logic [BB-1:0]                 cb6 [8];

  logic                          v7;
  logic [IB-1:0]                 m7 [2][4];
  logic [1:0][SPB-1:0]           fz7;
  logic [3:0][BB-1:0]            d1_num;
  logic [3:0][SPB-1:0]           d1_rem;
  logic [3:0][SPB-1:0]           d1_div;
  logic [3:0][BB-1:0]            q1;
  logic [2*SPB:0]                d1_side;

  logic                          v9;
  logic [IB-1:0]                 m9 [2][2];
  logic [1:0][BB-1:0]            d2_num;
  logic [1:0][SPB-1:0]           d2_rem;
  logic [1:0][BB-1:0]            q2;
  logic                          d2_valid;

  logic                          v10;
  logic [XB-1:0]                 s10;
  logic [XB+12:0]                blend_prod;
  logic                          out_valid;
  logic [fvn_pkg::HEIGHT_BITS-1:0] height;

  assign en  = !out_valid || result.ready;
  assign pop = en && !empty;

  assign sp_oct[0]   = sp_coarse;
  assign sp_oct[1]   = sp_fine;
  assign seed_oct[0] = seed ^ fvn_pkg::HASH_BASIS;
  assign seed_oct[1] = seed ^ fvn_pkg::FINE_SEED_XOR ^ fvn_pkg::HASH_BASIS;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      g[l]    = signed'(entry[l*LW + SPB +: COORD_BITS]);
      f_in[l] = entry[l*LW +: SPB];
    end
  end

  // lane h: octave h[2], corner offsets h[0] along x and h[1] along z
  always_comb begin
    logic signed [32:0] xs;
    logic signed [32:0] zs;
    for (int h = 0; h < 8; h++) begin
      xs = 33'(g[2*(h/4)])     + (((h & 1) != 0) ? 33'sd1 : 33'sd0);
      zs = 33'(g[2*(h/4) + 1]) + (((h & 2) != 0) ? 33'sd1 : 33'sd0);
      p1_next[h] = fvn_pkg::mul_parts(seed_oct[h/4] ^ {32'h0, xs[31:0]},
                                      fvn_pkg::HASH_MUL1);
      zi_next[h] = zs[31:0];
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] s;
    if (rst) begin
      hv        <= '0;
      v7        <= 1'b0;
      v9        <= 1'b0;
      v10       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      hv    <= {hv[5:1], !empty};
      fr[1] <= f_in;
      for (int k = 2; k <= 6; k++) begin
        fr[k] <= fr[k-1];
      end
      for (int h = 0; h < 8; h++) begin
        p1[h]  <= p1_next[h];
        zi1[h] <= zi_next[h];
        x2[h]  <= fvn_pkg::mul_sum(p1[h]) ^ {32'h0, zi1[h]};
        p3[h]  <= fvn_pkg::mul_parts(x2[h], fvn_pkg::HASH_MUL2);
        s       = fvn_pkg::mul_sum(p3[h]);
        x4[h]  <= s ^ (s >> 29);
        p5[h]  <= fvn_pkg::mul_parts(x4[h], fvn_pkg::HASH_MUL3);
        s       = fvn_pkg::mul_sum(p5[h]);
        cb6[h] <= s[7:0] ^ s[39:32];
      end
      v7 <= hv[6];
      for (int o = 0; o < 2; o++) begin
        m7[o][0] <= IB'(cb6[4*o])     * IB'(sp_oct[o] - fr[6][2*o]);
        m7[o][1] <= IB'(cb6[4*o + 1]) * IB'(fr[6][2*o]);
        m7[o][2] <= IB'(cb6[4*o + 2]) * IB'(sp_oct[o] - fr[6][2*o]);
        m7[o][3] <= IB'(cb6[4*o + 3]) * IB'(fr[6][2*o]);
        fz7[o]   <= fr[6][2*o + 1];
      end
      v9 <= d1_side[0];
      for (int o = 0; o < 2; o++) begin
        m9[o][0] <= IB'(q1[2*o])     * IB'(sp_oct[o] - d1_side[1 + o*SPB +: SPB]);
        m9[o][1] <= IB'(q1[2*o + 1]) * IB'(d1_side[1 + o*SPB +: SPB]);
      end
      v10       <= d2_valid;
      s10       <= XB'(7) * XB'(q2[0]) + XB'(3) * XB'(q2[1]);
      out_valid <= v10;
      height    <= blend_prod[23:16];
    end
  end

  assign blend_prod = (XB+13)'(s10) * (XB+13)'(fvn_pkg::DIV10_RECIP);

  // numerators stay below 256 * spacing, so the upper bits start as remainder
  always_comb begin
    logic [IB-1:0] n;
    for (int o = 0; o < 2; o++) begin
      n                = m7[o][0] + m7[o][1];
      d1_num[2*o]      = n[BB-1:0];
      d1_rem[2*o]      = n[IB-1:BB];
      n                = m7[o][2] + m7[o][3];
      d1_num[2*o + 1]  = n[BB-1:0];
      d1_rem[2*o + 1]  = n[IB-1:BB];
      d1_div[2*o]      = sp_oct[o];
      d1_div[2*o + 1]  = sp_oct[o];
      n                = m9[o][0] + m9[o][1];
      d2_num[o]        = n[BB-1:0];
      d2_rem[o]        = n[IB-1:BB];
    end
  end

  fvn_divider #(
    .LANES(4),
    .NB   (BB),
    .DB   (SPB),
    .SB   (2*SPB + 1)
  ) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .num_in  (d1_num),
    .rem_in  (d1_rem),
    .divisor (d1_div),
    .side_in ({fz7[1], fz7[0], v7}),
    .quo     (q1),
    .rem     (),
    .side_out(d1_side)
  );

  fvn_divider #(
    .LANES(2),
    .NB   (BB),
    .DB   (SPB),
    .SB   (1)
  ) u_div_z (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .num_in  (d2_num),
    .rem_in  (d2_rem),
    .divisor ({sp_oct[1], sp_oct[0]}),
    .side_in (v9),
    .quo     (q2),
    .rem     (),
    .side_out(d2_valid)
  );

  assign result.valid  = out_valid;
  assign result.height = height;

endmodule

`default_nettype wire

// ===== hw/rtl/fractal_value_noise_2d.sv =====
// top level of the two-octave fractal value noise height generator
//
//   channel  | role   | payload
//   ---------+--------+--------------------------------------------
//   coord    | sink   | x_coord, z_coord (COORD_BITS, signed)
//   result   | source | height (8 bits)
//   cfg      | write  | cfg_en, cfg_index (seed, span), cfg_data
//
// one coordinate accepted per cycle, one height per cycle sustained while the result is not stalled
// the result passes through COORD_BITS front
// divider registers, the queue, six hash stages, one product stage, a 9-register
// x divider, one product stage, a 9-register z divider and two blend stages
// reset is synchronous and loads seed 0 and span 512
// a stalled result freezes the back pipeline only; the four-entry queue lets
// the front keep accepting until it fills
`default_nettype none

module fractal_value_noise_2d #(
  parameter int COORD_BITS = fvn_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_en,
  input  logic [fvn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fvn_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  fvn_coord_if.sink                           coord,
  fvn_height_if.source                        result
);

  localparam int EW = 4 * (COORD_BITS + fvn_pkg::SP_BITS);

  logic [fvn_pkg::SEED_BITS-1:0] seed;
  logic [fvn_pkg::SPAN_BITS-1:0] span;
  logic [fvn_pkg::SP_BITS-1:0]   sp_coarse;
  logic [fvn_pkg::SP_BITS-1:0]   sp_fine;

  logic                          push;
  logic [EW-1:0]                 push_data;
  logic                          pop;
  logic [EW-1:0]                 pop_data;
  fvn_pkg::queue_status_t        q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= fvn_pkg::SEED_RESET;
      span      <= fvn_pkg::SPAN_RESET;
      sp_coarse <= fvn_pkg::spacing_coarse(fvn_pkg::SPAN_RESET);
      sp_fine   <= fvn_pkg::spacing_fine(fvn_pkg::SPAN_RESET);
    end else begin
      if (cfg_en) begin
        unique case (fvn_pkg::cfg_reg_t'(cfg_index))
          fvn_pkg::CFG_SEED: begin
            seed <= cfg_data;
          end
          fvn_pkg::CFG_SPAN: begin
            span <= cfg_data[fvn_pkg::SPAN_BITS-1:0];
          end
        endcase
      end
      sp_coarse <= fvn_pkg::spacing_coarse(span);
      sp_fine   <= fvn_pkg::spacing_fine(span);
    end
  end

  fvn_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .coord    (coord),
    .sp_coarse(sp_coarse),
    .sp_fine  (sp_fine),
    .full     (q_stat.full),
    .push     (push),
    .push_data(push_data)
  );

  fvn_queue #(
    .WIDTH(EW),
    .DEPTH(fvn_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .status   (q_stat)
  );

  fvn_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_stat.empty),
    .entry    (pop_data),
    .pop      (pop),
    .seed     (seed),
    .sp_coarse(sp_coarse),
    .sp_fine  (sp_fine),
    .result   (result)
  );

  a_rst_no_result: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !pop)
    else $error("queue popped while result stalled");

  a_full_no_push: assert property (@(posedge clk) disable iff (rst)
    q_stat.full && !pop |=> !push)
    else $error("push into full queue");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

endmodule

`default_nettype wire

// ===== bench/fvn_bench_if.sv =====
// spare file slot: channel interfaces come from hw/rtl/fvn_if.sv
`default_nettype none
`default_nettype wire

// ===== bench/testbench.sv =====
// testbench for fractal_value_noise_2d: directed table then random coordinates
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fvn_pkg::*;

  localparam int CB = COORD_BITS_DEFAULT;
  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] z;
    int                   hgt;
  } coord_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_en = 0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_SEED;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  fvn_coord_if #(.COORD_BITS(CB)) coord ();
  fvn_height_if result ();

  fractal_value_noise_2d #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst), .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .coord(coord), .result(result)
  );

  logic [63:0] seed_q = SEED_RESET;
  logic [11:0] span_q = SPAN_RESET;
  logic [7:0] heights_due[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] lattice_byte(logic [63:0] s, longint gx, longint gz);
    logic [63:0] h;
    h = s ^ HASH_BASIS;
    h = (h ^ {32'h0, gx[31:0]}) * HASH_MUL1;
    h = (h ^ {32'h0, gz[31:0]}) * HASH_MUL2;
    h = h ^ (h >> 29);
    h = h * HASH_MUL3;
    h = h ^ (h >> 32);
    return h[7:0];
  endfunction

  function automatic longint floor_q(longint v, longint d);
    longint q;
    q = v / d;
    if (v < 0 && q * d != v) q = q - 1;
    return q;
  endfunction

  function automatic longint octave_height(logic [63:0] s, longint cx, longint cz, longint sp);
    longint gx, gz, fx, fz, c00, c10, c01, c11, top, bot;
    gx = floor_q(cx, sp);
    gz = floor_q(cz, sp);
    fx = cx - gx * sp;
    fz = cz - gz * sp;
    c00 = lattice_byte(s, gx, gz);
    c10 = lattice_byte(s, gx + 1, gz);
    c01 = lattice_byte(s, gx, gz + 1);
    c11 = lattice_byte(s, gx + 1, gz + 1);
    top = (c00 * (sp - fx) + c10 * fx) / sp;
    bot = (c01 * (sp - fx) + c11 * fx) / sp;
    return (top * (sp - fz) + bot * fz) / sp;
  endfunction

  function automatic logic [7:0] noise_height(logic signed [CB-1:0] x, logic signed [CB-1:0] z);
    longint l1, l2, a, b;
    l1 = span_q / 5;
    l2 = span_q / 11;
    if (l1 < 8) l1 = 8;
    if (l2 < 4) l2 = 4;
    a = octave_height(seed_q, longint'(x), longint'(z), l1);
    b = octave_height(seed_q ^ FINE_SEED_XOR, longint'(x), longint'(z), l2);
    return 8'((a * 7 + b * 3) / 10);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_en <= 0;
    if (idx == CFG_SEED) seed_q = val;
    else span_q = val[11:0];
  endtask

  task automatic send_coord(logic signed [CB-1:0] x, logic signed [CB-1:0] z, int hgt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      coord.valid <= 0;
      @(negedge clk);
    end
    coord.valid <= 1;
    coord.x_coord <= x;
    coord.z_coord <= z;
    do @(posedge clk); while (!coord.ready);
    heights_due.insert(heights_due.size(), hgt >= 0 ? 8'(hgt) : noise_height(x, z));
  endtask

  task automatic drain();
    @(negedge clk);
    coord.valid <= 0;
    wait (heights_due.size() == 0);
    repeat (CB + 40) @(negedge clk);
  endtask

  initial begin
    coord.valid = 0;
    coord.x_coord = '0;
    coord.z_coord = '0;
    result.ready = 1;
    forever begin
      @(negedge clk);
      result.ready <= !($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && result.valid && result.ready) begin
      if (heights_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected transaction height=%0d", result.height);
      end else begin
        if (result.height !== heights_due[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("height mismatch: expected %0d got %0d", heights_due[0], result.height);
        end
        void'(heights_due.pop_front());
      end
    end
  end

  coord_row_t directed[] = '{
    '{16'sd0, 16'sd0, -1}, '{16'sd32767, 16'sd32767, -1}, '{-16'sd32768, -16'sd32768, -1},
    '{16'sd32767, -16'sd32768, -1}, '{-16'sd32768, 16'sd32767, -1}, '{-16'sd1, -16'sd1, -1},
    '{16'sd1, -16'sd1, -1}, '{-16'sd101, 16'sd7, -1}, '{16'sd102, 16'sd103, -1},
    '{16'sh5555, 16'shAAAA, -1}, '{16'shAAAA, 16'sh5555, -1}, '{-16'sd4, -16'sd8, -1}
  };

  initial begin
    int phase;
    logic [11:0] spans[6];
    spans = '{12'd512, 12'd0, 12'd1, 12'd4095, 12'd44, 12'd60};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (directed[i]) send_coord(directed[i].x, directed[i].z, directed[i].hgt);
    drain();
    for (phase = 0; phase < 6; phase++) begin
      write_reg(CFG_SPAN, {52'h0, spans[phase]});
      write_reg(CFG_SEED, phase == 1 ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
      case (phase % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 61; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 61; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      for (int k = 0; k < 125; k++) begin
        logic [15:0] rx, rz;
        rx = 16'($urandom);
        rz = 16'($urandom);
        if (k % 3 == 0) begin rx = 16'($urandom_range(64)) - 16'd32; end
        send_coord(rx, rz, -1);
        if (k == 60) drain();
      end
      drain();
    end
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire
